// ----- src/rtc_bcd_to_seconds_sync_filter_assert.svh -----
// Assertion macros used by the RTL file; clock is clk, reset is arst_n.
`ifndef RTC_BCD_TO_SECONDS_SYNC_FILTER_ASSERT_SVH
`define RTC_BCD_TO_SECONDS_SYNC_FILTER_ASSERT_SVH

// Same-cycle implication.
`define RBTS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RBTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/rbts_pkg.sv -----
`default_nettype none

package rbts_pkg;

	// Result verdict codes
	typedef logic [1:0] verdict_t;
	localparam verdict_t VERDICT_ACCEPT   = 2'd0;
	localparam verdict_t VERDICT_BACKWARD = 2'd1;
	localparam verdict_t VERDICT_FORWARD  = 2'd2;

	// Configuration register indexes
	typedef logic [0:0] reg_index_t;
	localparam reg_index_t REG_ACCEPT_WINDOW = 1'b0;
	localparam reg_index_t REG_ERROR_LIMIT   = 1'b1;

	localparam logic [7:0] ACCEPT_WINDOW_RESET = 8'd3;
	localparam logic [7:0] ERROR_LIMIT_RESET   = 8'd10;

	// Multiply-accumulate steps of the conversion sequencer
	typedef logic [2:0] mac_step_t;
	localparam mac_step_t STEP_DAYS     = 3'd0;
	localparam mac_step_t STEP_DAY_SECS = 3'd1;
	localparam mac_step_t STEP_HOURS    = 3'd2;
	localparam mac_step_t STEP_MINUTES  = 3'd3;
	localparam mac_step_t STEP_SECONDS  = 3'd4;

	// Multiplier constants
	localparam logic [16:0] DAYS_PER_YEAR = 17'd365;
	localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
	localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
	localparam logic [16:0] SECS_PER_MIN  = 17'd60;
	localparam logic [16:0] SECS_UNIT     = 17'd1;

	// Drop bit 7, then low nibble plus ten times the upper three bits (0..85)
	function automatic logic [6:0] decode_bcd(input logic [7:0] raw);
		logic [6:0] tens;
		tens = {4'd0, raw[6:4]};
		return 7'({3'd0, raw[3:0]} + 7'(tens * 7'd10));
	endfunction

	// Days before the first of the month; months outside 1..12 add nothing
	function automatic logic [8:0] month_offset(input logic [6:0] month);
		logic [8:0] off;
		case (month)
			7'd2:    off = 9'd31;
			7'd3:    off = 9'd59;
			7'd4:    off = 9'd90;
			7'd5:    off = 9'd120;
			7'd6:    off = 9'd151;
			7'd7:    off = 9'd181;
			7'd8:    off = 9'd212;
			7'd9:    off = 9'd243;
			7'd10:   off = 9'd273;
			7'd11:   off = 9'd304;
			7'd12:   off = 9'd334;
			default: off = 9'd0;
		endcase
		return off;
	endfunction

endpackage

`default_nettype wire

// ----- src/rtc_bcd_to_seconds_sync_filter.sv -----
`default_nettype none

// RTC reading to seconds since 2000 with a plausibility filter. One input word
// carries six raw BCD bytes; one output word follows per input word. The
// conversion runs on a single 32x17 multiply-accumulate unit stepped five
// times (year days, day seconds, hours, minutes, seconds), then one filter
// step, and the next item is taken only once that filter step has completed;
// s_axis_tready is high only while the sequencer is idle. A finished word
// waits in the output register, and the filter cycle holds until that register
// is free. accept_window and error_limit are written through wr_en/wr_index/
// wr_data and should only change while the block is idle.
module rtc_bcd_to_seconds_sync_filter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        wr_en,
	input  wire logic [0:0]  wr_index,
	input  wire logic [7:0]  wr_data,
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// tdata: seconds_bcd, minutes_bcd, hours_bcd, date_bcd, month_bcd, year_bcd
	input  wire logic [47:0] s_axis_tdata,
	// output stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// tdata: reading_seconds, held_seconds
	output logic [63:0]      m_axis_tdata,
	// tuser: verdict[1:0], resynced
	output logic [2:0]       m_axis_tuser
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MAC  = 2'd1;
	localparam logic [1:0] S_FILT = 2'd2;

	logic [1:0]             state_q;
	rbts_pkg::mac_step_t    step_q;
	logic [6:0]             sec_q, min_q, hour_q, date_q, month_q, year_q;
	logic [31:0]            acc_q;
	logic [7:0]             window_q, limit_q;
	logic [31:0]            ref_q, held_q;
	logic [7:0]             bwd_run_q, fwd_run_q;
	logic                   out_valid_q;
	logic [31:0]            out_reading_q, out_held_q;
	rbts_pkg::verdict_t     out_verdict_q;
	logic                   out_resync_q;

	logic        in_fire, filt_go;
	logic [31:0] mac_a, mac_c, days_extra, mac_sum;
	logic [16:0] mac_b;
	logic [31:0] mac_prod;
	logic        leap_fix;

	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign filt_go       = (state_q == S_FILT) && (!out_valid_q || m_axis_tready);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= rbts_pkg::ACCEPT_WINDOW_RESET;
			limit_q  <= rbts_pkg::ERROR_LIMIT_RESET;
		end else if (wr_en) begin
			case (wr_index)
				rbts_pkg::REG_ACCEPT_WINDOW: window_q <= wr_data;
				rbts_pkg::REG_ERROR_LIMIT:   limit_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// Narrow day terms: leap quarter, date, month offset, leap-day correction
	assign leap_fix   = (year_q[1:0] == 2'd0) && (month_q < 7'd3);
	assign days_extra = 32'(year_q[6:2]) + 32'(date_q)
		+ 32'(rbts_pkg::month_offset(month_q)) - 32'(leap_fix);

	// Select operands for the shared multiply-accumulate unit
	always_comb begin
		case (step_q)
			rbts_pkg::STEP_DAYS: begin
				mac_a = 32'(year_q);
				mac_b = rbts_pkg::DAYS_PER_YEAR;
				mac_c = days_extra;
			end
			rbts_pkg::STEP_DAY_SECS: begin
				mac_a = acc_q;
				mac_b = rbts_pkg::SECS_PER_DAY;
				mac_c = 32'd0;
			end
			rbts_pkg::STEP_HOURS: begin
				mac_a = 32'(hour_q);
				mac_b = rbts_pkg::SECS_PER_HOUR;
				mac_c = acc_q;
			end
			rbts_pkg::STEP_MINUTES: begin
				mac_a = 32'(min_q);
				mac_b = rbts_pkg::SECS_PER_MIN;
				mac_c = acc_q;
			end
			rbts_pkg::STEP_SECONDS: begin
				mac_a = 32'(sec_q);
				mac_b = rbts_pkg::SECS_UNIT;
				mac_c = acc_q;
			end
			default: begin
				mac_a = 32'd0;
				mac_b = 17'd0;
				mac_c = 32'd0;
			end
		endcase
	end

	// Keep the low 32 bits of the product; the count wraps mod 2^32
	assign mac_prod = mac_a * {15'd0, mac_b};
	assign mac_sum  = mac_prod + mac_c;

	// Filter decision on the finished count
	logic        is_backward, in_window;
	logic [31:0] step_diff;
	logic [7:0]  bwd_next, fwd_next;
	logic [31:0] ref_next, held_next;
	logic        resync;
	rbts_pkg::verdict_t verdict;

	assign step_diff   = acc_q - ref_q;
	assign is_backward = acc_q < ref_q;
	assign in_window   = step_diff <= {24'd0, window_q};

	always_comb begin
		ref_next  = ref_q;
		held_next = held_q;
		resync    = 1'b0;
		if (is_backward) begin
			bwd_next = bwd_run_q + 8'd1;
			fwd_next = 8'd0;
			verdict  = rbts_pkg::VERDICT_BACKWARD;
		end else if (in_window) begin
			bwd_next  = 8'd0;
			fwd_next  = 8'd0;
			ref_next  = acc_q;
			held_next = acc_q;
			verdict   = rbts_pkg::VERDICT_ACCEPT;
		end else begin
			bwd_next = 8'd0;
			fwd_next = fwd_run_q + 8'd1;
			verdict  = rbts_pkg::VERDICT_FORWARD;
		end
		// Resynchronize the reference once a run reaches the limit
		if (verdict != rbts_pkg::VERDICT_ACCEPT && (bwd_next >= limit_q || fwd_next >= limit_q))
		begin
			ref_next = acc_q;
			bwd_next = 8'd0;
			fwd_next = 8'd0;
			resync   = 1'b1;
		end
	end

	// Sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			step_q    <= rbts_pkg::STEP_DAYS;
			ref_q     <= 32'd0;
			held_q    <= 32'd0;
			bwd_run_q <= 8'd0;
			fwd_run_q <= 8'd0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_MAC;
						step_q  <= rbts_pkg::STEP_DAYS;
					end
				end
				S_MAC: begin
					if (step_q == rbts_pkg::STEP_SECONDS) begin
						state_q <= S_FILT;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				S_FILT: begin
					if (filt_go) begin
						state_q   <= S_IDLE;
						ref_q     <= ref_next;
						held_q    <= held_next;
						bwd_run_q <= bwd_next;
						fwd_run_q <= fwd_next;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Decode fields on accept; accumulate during the MAC steps
	always_ff @(posedge clk) begin
		if (in_fire) begin
			sec_q   <= rbts_pkg::decode_bcd(s_axis_tdata[7:0]);
			min_q   <= rbts_pkg::decode_bcd(s_axis_tdata[15:8]);
			hour_q  <= rbts_pkg::decode_bcd(s_axis_tdata[23:16]);
			date_q  <= rbts_pkg::decode_bcd(s_axis_tdata[31:24]);
			month_q <= rbts_pkg::decode_bcd(s_axis_tdata[39:32]);
			year_q  <= rbts_pkg::decode_bcd(s_axis_tdata[47:40]);
		end
		if (state_q == S_MAC) begin
			acc_q <= mac_sum;
		end
	end

	// Output register: load on filter step, drop on handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (filt_go) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (filt_go) begin
			out_reading_q <= acc_q;
			out_held_q    <= held_next;
			out_verdict_q <= verdict;
			out_resync_q  <= resync;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_held_q, out_reading_q};
	assign m_axis_tuser  = {out_resync_q, out_verdict_q};

	`include "rtc_bcd_to_seconds_sync_filter_assert.svh"

	`RBTS_ASSERT_NEXT(a_accept_starts_mac, in_fire,
		state_q == S_MAC && step_q == rbts_pkg::STEP_DAYS, "accept did not start conversion")
	`RBTS_ASSERT_NOW(a_one_run_active, 1'b1,
		bwd_run_q == 8'd0 || fwd_run_q == 8'd0, "both error runs nonzero")
	`RBTS_ASSERT_NOW(a_accept_holds_reading,
		out_valid_q && out_verdict_q == rbts_pkg::VERDICT_ACCEPT,
		out_held_q == out_reading_q && !out_resync_q, "accepted word not held")
	`RBTS_ASSERT_NEXT(a_filter_waits, state_q == S_FILT && out_valid_q && !m_axis_tready,
		state_q == S_FILT, "filter step overwrote pending word")

endmodule

`default_nettype wire
